// ===== hdl/pdp_pkg.sv =====
// shared types and constants for the packed int2 scaled dot product unit
// used by pdp_front, pdp_queue, pdp_back and the top level
`default_nettype none

package pdp_pkg;

  localparam int LANES       = 4;
  localparam int ACC_W       = 18;
  localparam int SCALE_W     = 16;
  localparam int SHIFT_W     = 5;
  localparam int LANE_SUM_W  = 6;
  localparam int PROD1_W     = ACC_W + SCALE_W;
  localparam int PROD2_W     = PROD1_W + SCALE_W;
  localparam int RESULT_W    = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;

  localparam logic signed [ACC_W:0] ACC_MAX = 19'sd131071;
  localparam logic signed [ACC_W:0] ACC_MIN = -19'sd131072;

  localparam logic signed [RESULT_W-1:0] RES_MAX = 32'sh7fff_ffff;
  localparam logic signed [RESULT_W-1:0] RES_MIN = 32'sh8000_0000;

  // one finished dot product waiting for scaling
  typedef struct packed {
    logic signed [ACC_W-1:0]   acc;
    logic signed [SCALE_W-1:0] row;
    logic signed [SCALE_W-1:0] col;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL_COL,
    B_SAT
  } back_state_t;

  // lane product of two packed 2-bit signed values
  function automatic logic signed [3:0] lane_product(input logic [1:0] a,
                                                     input logic [1:0] b);
    logic signed [3:0] sa;
    logic signed [3:0] sb;
    sa = 4'(signed'(a));
    sb = 4'(signed'(b));
    return 4'(sa * sb);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pdp_front.sv =====
// front end: accepts byte pairs, accumulates lane products, emits jobs on last
// depends on pdp_pkg
`default_nettype none

module pdp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [7:0]    a_byte,
  input  wire logic [7:0]    b_byte,
  input  wire logic          last,
  input  wire logic [15:0]   row_scale,
  input  wire logic [15:0]   col_scale,
  input  wire logic          queue_full,
  output logic               in_ready,
  output logic               push,
  output pdp_pkg::job_t      push_job
);

  logic signed [pdp_pkg::ACC_W-1:0]      acc;
  logic signed [pdp_pkg::LANE_SUM_W-1:0] lane_sum;
  logic signed [pdp_pkg::ACC_W:0]        wide_sum;
  logic signed [pdp_pkg::ACC_W-1:0]      acc_next;
  logic                                  take;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < pdp_pkg::LANES; i++) begin
      lane_sum = lane_sum + pdp_pkg::LANE_SUM_W'(
        pdp_pkg::lane_product(a_byte[2*i +: 2], b_byte[2*i +: 2]));
    end
    wide_sum = (pdp_pkg::ACC_W + 1)'(acc) + (pdp_pkg::ACC_W + 1)'(lane_sum);
    // clamp instead of wrapping on overlong runs
    if (wide_sum > pdp_pkg::ACC_MAX) begin
      acc_next = pdp_pkg::ACC_W'(pdp_pkg::ACC_MAX);
    end else if (wide_sum < pdp_pkg::ACC_MIN) begin
      acc_next = pdp_pkg::ACC_W'(pdp_pkg::ACC_MIN);
    end else begin
      acc_next = pdp_pkg::ACC_W'(wide_sum);
    end
  end

  assign push         = take && last;
  assign push_job.acc = acc_next;
  assign push_job.row = signed'(row_scale);
  assign push_job.col = signed'(col_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (take) begin
      acc <= last ? '0 : acc_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && last) |=> (acc == '0))
    else $error("accumulator not cleared after last");
`endif

endmodule

`default_nettype wire

// ===== hdl/pdp_queue.sv =====
// short job queue between the front end and the scaling back end
// depends on pdp_pkg
`default_nettype none

module pdp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pdp_pkg::job_t push_job,
  input  wire logic          pop,
  output pdp_pkg::job_t      head,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = $clog2(pdp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pdp_pkg::QUEUE_DEPTH + 1);

  pdp_pkg::job_t    slots [pdp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(pdp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pdp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pdp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/pdp_back.sv =====
// back end: scales a finished sum by row and column scale, shifts, saturates
// depends on pdp_pkg; holds the result_shift register and the output register
`default_nettype none

module pdp_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pdp_pkg::SHIFT_W-1:0]    cfg_wdata,
  input  wire pdp_pkg::job_t                  head,
  input  wire logic                           empty,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [pdp_pkg::RESULT_W-1:0]        scaled_result,
  output logic                                saturated
);

  pdp_pkg::back_state_t state;
  pdp_pkg::back_state_t state_next;

  logic [pdp_pkg::SHIFT_W-1:0]          result_shift;
  logic signed [pdp_pkg::PROD1_W-1:0]   p1;
  logic signed [pdp_pkg::SCALE_W-1:0]   col;
  logic signed [pdp_pkg::PROD2_W-1:0]   p2;
  logic signed [pdp_pkg::PROD2_W-1:0]   shifted;
  logic [pdp_pkg::PROD2_W-pdp_pkg::RESULT_W:0] top_bits;
  logic signed [pdp_pkg::RESULT_W-1:0]  sat_value;
  logic                                 sat_flag;
  logic                                 load_out;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      pdp_pkg::B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = pdp_pkg::B_MUL_COL;
        end
      end
      pdp_pkg::B_MUL_COL: begin
        state_next = pdp_pkg::B_SAT;
      end
      pdp_pkg::B_SAT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = pdp_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = pdp_pkg::B_IDLE;
      end
    endcase
  end

  // arithmetic shift floors, then clip to 32 bits
  always_comb begin
    shifted  = p2 >>> result_shift;
    top_bits = shifted[pdp_pkg::PROD2_W-1:pdp_pkg::RESULT_W-1];
    if (!shifted[pdp_pkg::PROD2_W-1] && (|top_bits)) begin
      sat_value = pdp_pkg::RES_MAX;
      sat_flag  = 1'b1;
    end else if (shifted[pdp_pkg::PROD2_W-1] && !(&top_bits)) begin
      sat_value = pdp_pkg::RES_MIN;
      sat_flag  = 1'b1;
    end else begin
      sat_value = shifted[pdp_pkg::RESULT_W-1:0];
      sat_flag  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdp_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_shift <= pdp_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      result_shift <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1  <= pdp_pkg::PROD1_W'(head.acc) * pdp_pkg::PROD1_W'(head.row);
      col <= head.col;
    end
    if (state == pdp_pkg::B_MUL_COL) begin
      p2 <= pdp_pkg::PROD2_W'(p1) * pdp_pkg::PROD2_W'(col);
    end
    if (load_out) begin
      scaled_result <= sat_value;
      saturated     <= sat_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pop_starts_job: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == pdp_pkg::B_MUL_COL))
    else $error("pop did not start a scaling job");
`endif

endmodule

`default_nettype wire

// ===== hdl/packed_int2_scaled_dot_product_unit.sv =====
// packed int2 dot product with Q1.15 row and column scales
// top level: instantiates pdp_front, pdp_queue and pdp_back; uses pdp_pkg
//
// s_axis carries byte pairs of A and B along K; tlast marks the last pair of a
// dot product, and only on that pair are the row and column scales used.
// Every pair adds four signed 2-bit lane products into an 18-bit accumulator
// that clips instead of wrapping. m_axis returns one result per tlast: the
// sum times both scales, arithmetic right shift by result_shift, clipped to
// signed 32 bits, with tuser set when clipping happened.
// cfg_we writes cfg_wdata into result_shift (reset value 14); write it only
// while the unit is idle.
// Throughput: one pair per cycle while the two-entry job queue has room. The
// scaling sequencer finishes one dot product (two multiply steps, then shift
// and clip) before it pops the next, so back-to-back tlast pairs wait in the
// queue. A result then passes through p1, p2 and the output register.
// When m_axis stalls the result waits in the output register, the sequencer
// holds its next result, the queue fills, and then s_axis_tready drops.
// Synchronous reset clears the accumulator, the queue, the sequencer and the
// output valid, and restores result_shift to 14.
`default_nettype none

module packed_int2_scaled_dot_product_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // a_byte [7:0], b_byte [15:8], row_scale [31:16], col_scale [47:32]
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scaled_result [31:0]
  output logic [31:0]      m_axis_tdata,
  // saturated [0]
  output logic             m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);

  pdp_pkg::job_t push_job;
  pdp_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          queue_full;
  logic          queue_empty;

  pdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .a_byte     (s_axis_tdata[7:0]),
    .b_byte     (s_axis_tdata[15:8]),
    .last       (s_axis_tlast),
    .row_scale  (s_axis_tdata[31:16]),
    .col_scale  (s_axis_tdata[47:32]),
    .queue_full (queue_full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_job   (push_job)
  );

  pdp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  pdp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .head          (head),
    .empty         (queue_empty),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .scaled_result (m_axis_tdata),
    .saturated     (m_axis_tuser)
  );

endmodule

`default_nettype wire
